// File: hw/rtl/sssc_pkg.sv
// ----------------------------------------------------------------------------
// sssc_pkg
// Shared types, function codes and font table for the seven-segment scan
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sssc_pkg;

  localparam int NUM_DIGITS_DEF  = 4;
  localparam int NUM_COLUMNS_DEF = 5;

  // Function codes carried in the input tuser
  localparam logic [2:0] FUNC_TICK    = 3'd0;
  localparam logic [2:0] FUNC_CHAR    = 3'd1;
  localparam logic [2:0] FUNC_PATTERN = 3'd2;
  localparam logic [2:0] FUNC_NUMBER  = 3'd3;
  localparam logic [2:0] FUNC_MODE    = 3'd4;
  localparam logic [2:0] FUNC_LAMP    = 3'd5;

  localparam logic [7:0] FONT_FIRST = 8'h30;
  localparam logic [7:0] FONT_LAST  = 8'h5F;

  // Reciprocal of ten for a 16-bit dividend: q = (n * 0xCCCD) >> 19
  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;

  // Controller to datapath commands
  typedef struct packed {
    logic tick;
    logic set_char;
    logic set_pattern;
    logic num_load;
    logic num_step;
    logic set_mode;
    logic set_lamp;
  } sssc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;
    logic digit_last;
  } sssc_status_t;

  function automatic logic [7:0] font_glyph(input logic [5:0] idx);
    logic [7:0] g;
    unique case (idx)
      6'd0:  g = 8'h3F;  6'd1:  g = 8'h06;  6'd2:  g = 8'h5B;  6'd3:  g = 8'h4F;
      6'd4:  g = 8'h66;  6'd5:  g = 8'h6D;  6'd6:  g = 8'h7D;  6'd7:  g = 8'h27;
      6'd8:  g = 8'h7F;  6'd9:  g = 8'h6F;  6'd10: g = 8'h41;  6'd11: g = 8'h45;
      6'd12: g = 8'h58;  6'd13: g = 8'h48;  6'd14: g = 8'h4C;  6'd15: g = 8'h53;
      6'd16: g = 8'h7B;  6'd17: g = 8'h77;  6'd18: g = 8'h7C;  6'd19: g = 8'h39;
      6'd20: g = 8'h5E;  6'd21: g = 8'h79;  6'd22: g = 8'h71;  6'd23: g = 8'h3D;
      6'd24: g = 8'h76;  6'd25: g = 8'h30;  6'd26: g = 8'h0E;  6'd27: g = 8'h78;
      6'd28: g = 8'h38;  6'd29: g = 8'h37;  6'd30: g = 8'h54;  6'd31: g = 8'h5C;
      6'd32: g = 8'h73;  6'd33: g = 8'h67;  6'd34: g = 8'h50;  6'd35: g = 8'h2D;
      6'd36: g = 8'h31;  6'd37: g = 8'h3E;  6'd38: g = 8'h1C;  6'd39: g = 8'h6A;
      6'd40: g = 8'h46;  6'd41: g = 8'h6E;  6'd42: g = 8'h1B;  6'd43: g = 8'h39;
      6'd44: g = 8'h60;  6'd45: g = 8'h0F;  6'd46: g = 8'h01;  6'd47: g = 8'h08;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/seven_segment_scan_controller.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_controller
// Multiplexed seven-segment display driver with character, raw, number and
// indicator writes and a scan tick that emits one column per beat.
// ----------------------------------------------------------------------------
// Each input beat is one command selected by tuser. A tick beat emits the
// current column and its active-low segments on the output stream, then
// advances the column with wrap; the result is valid the cycle after the tick
// is taken. Any input beat is taken only while the output register is empty
// or being drained, so a stalled output beat holds off writes as well as
// ticks. Char, pattern, play mode and lamp writes update the store from the
// beat alone. A number write loads the value from its beat, then the
// divide-by-ten unit (one reciprocal multiply) makes one decimal digit per
// cycle, rightmost first, and input is held off until the last digit is
// stored. The pattern store is cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_scan_controller
  import sssc_pkg::*;
#(
  parameter int NUM_DIGITS  = NUM_DIGITS_DEF,
  parameter int NUM_COLUMNS = NUM_COLUMNS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // position[2:0], char_code[10:3], pattern[18:11], number[34:19],
  // min_digits[42:35], play_mode[44:43], lamp_on[45], zero pad[47:46]
  input  wire logic [47:0] s_axis_tdata,
  // func[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // column_index[2:0], segments_low[9:3], zero pad[15:10]
  output logic [15:0]      m_axis_tdata
);

  sssc_cmd_t    cmd;
  sssc_status_t status;
  logic [2:0]   column_index;
  logic [6:0]   segments_low;

  sssc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .func     (s_axis_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  sssc_datapath #(
    .NUM_DIGITS  (NUM_DIGITS),
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .position     (s_axis_tdata[2:0]),
    .char_code    (s_axis_tdata[10:3]),
    .pattern      (s_axis_tdata[18:11]),
    .number       (s_axis_tdata[34:19]),
    .min_digits   (s_axis_tdata[42:35]),
    .play_mode    (s_axis_tdata[44:43]),
    .lamp_on      (s_axis_tdata[45]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .column_index (column_index),
    .segments_low (segments_low)
  );

  assign m_axis_tdata = {6'b000000, segments_low, column_index};

endmodule

`default_nettype wire

// File: hw/rtl/sssc_ctrl.sv
// ----------------------------------------------------------------------------
// sssc_ctrl
// Control state machine: decodes input beats into datapath commands and
// sequences the digit-by-digit number conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module sssc_ctrl
  import sssc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [2:0]   func,
  input  wire sssc_status_t status,
  output sssc_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE    = 2'b01,
    ST_CONVERT = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE) && !status.out_busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    state_next   = state;
    cmd.num_step = (state == ST_CONVERT);
    if (accept) begin
      unique case (func)
        FUNC_TICK:    cmd.tick        = 1'b1;
        FUNC_CHAR:    cmd.set_char    = 1'b1;
        FUNC_PATTERN: cmd.set_pattern = 1'b1;
        FUNC_NUMBER: begin
          cmd.num_load = 1'b1;
          state_next   = ST_CONVERT;
        end
        FUNC_MODE:    cmd.set_mode    = 1'b1;
        FUNC_LAMP:    cmd.set_lamp    = 1'b1;
        default:      ; // unused codes: drop the beat
      endcase
    end
    if (state == ST_CONVERT && status.digit_last) begin
      state_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sssc_datapath.sv
// ----------------------------------------------------------------------------
// sssc_datapath
// Pattern store, scan column counter, divide-by-ten digit unit and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sssc_datapath
  import sssc_pkg::*;
#(
  parameter int NUM_DIGITS  = NUM_DIGITS_DEF,
  parameter int NUM_COLUMNS = NUM_COLUMNS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sssc_cmd_t          cmd,
  output sssc_status_t            status,
  input  wire logic [2:0]         position,
  input  wire logic [7:0]         char_code,
  input  wire logic [7:0]         pattern,
  input  wire logic [15:0]        number,
  input  wire logic signed [7:0]  min_digits,
  input  wire logic [1:0]         play_mode,
  input  wire logic               lamp_on,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              column_index,
  output logic [6:0]              segments_low
);

  localparam int CW = $clog2(NUM_COLUMNS);
  localparam int DW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic [7:0]        store [NUM_COLUMNS];
  logic [7:0]        store_next [NUM_COLUMNS];
  logic [CW-1:0]     scan_col;
  logic [15:0]       num;
  logic signed [7:0] cnt;
  logic [DW-1:0]     digit_k;

  logic [31:0] prod;
  logic [15:0] quot;
  logic [15:0] quot_x10;
  logic [3:0]  rem;
  logic        cnt_pos;
  logic [7:0]  digit_pat;
  logic [7:0]  char_pat;
  logic        in_font;
  logic [7:0]  font_off;

  // Divide by ten through the reciprocal multiply
  assign prod     = num * DIV10_MUL;
  assign quot     = 16'(prod[31:DIV10_SHIFT]);
  assign quot_x10 = {quot[12:0], 3'b000} + {quot[14:0], 1'b0};
  assign rem      = 4'(num - quot_x10);
  assign cnt_pos  = !cnt[7] && (cnt != 8'sd0);

  assign digit_pat = (num != 16'd0 || cnt_pos) ? font_glyph({2'b00, rem}) : 8'h00;

  assign in_font  = (char_code >= FONT_FIRST) && (char_code <= FONT_LAST);
  assign font_off = char_code - FONT_FIRST;
  assign char_pat = in_font ? font_glyph(font_off[5:0]) : 8'h00;

  assign status.out_busy   = out_valid && !out_ready;
  assign status.digit_last = (digit_k == '0);

  always_comb begin
    for (int i = 0; i < NUM_COLUMNS; i++) begin
      store_next[i] = store[i];
      if (cmd.set_char && int'(position) == i && int'(position) < NUM_DIGITS) begin
        store_next[i] = char_pat;
      end
      if (cmd.set_pattern && int'(position) == i) begin
        store_next[i] = pattern;
      end
      if (cmd.num_step && int'(digit_k) == i) begin
        store_next[i] = digit_pat;
      end
      if (cmd.set_mode && i == NUM_DIGITS) begin
        store_next[i][1:0] = play_mode;
      end
      if (cmd.set_lamp && i == NUM_DIGITS) begin
        store_next[i][4] = lamp_on;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COLUMNS; i++) begin
        store[i] <= 8'h00;
      end
      scan_col  <= '0;
      out_valid <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_COLUMNS; i++) begin
        store[i] <= store_next[i];
      end
      if (cmd.tick) begin
        out_valid <= 1'b1;
        scan_col  <= (scan_col == CW'(NUM_COLUMNS - 1)) ? '0 : scan_col + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output beat payload
  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      column_index <= 3'(scan_col);
      segments_low <= ~store[scan_col][6:0];
    end
  end

  // Number conversion registers, rightmost digit first
  always_ff @(posedge clk) begin
    if (cmd.num_load) begin
      num     <= number;
      cnt     <= min_digits;
      digit_k <= DW'(NUM_DIGITS - 1);
    end else if (cmd.num_step) begin
      num     <= quot;
      digit_k <= digit_k - 1'b1;
      if (cnt_pos) begin
        cnt <= cnt - 8'sd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: bench/seven_segment_scan_controller_tb.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_controller_tb
// Self-checking bench for the multiplexed seven-segment scan controller.
// ----------------------------------------------------------------------------
// Drives command beats on the input stream and keeps a shadow copy of the
// pattern store and scan column. Every accepted tick pushes the expected
// column and active-low segments. A checker compares each output beat with
// the oldest expected beat, field by field. The sender idles in random bursts
// and the receiver stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------

module seven_segment_scan_controller_tb;
  import sssc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_DIGITS       = 4;
  localparam int NUM_COLUMNS      = 5;
  localparam int RANDOM_ITEMS     = 1000;
  localparam int BACK_TO_BACK     = 150;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int SETTLE_CYCLES    = 16;

  // Codes the block does not decode
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

  localparam logic [7:0] GLYPH_ROM [48] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27,
    8'h7F, 8'h6F, 8'h41, 8'h45, 8'h58, 8'h48, 8'h4C, 8'h53,
    8'h7B, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D,
    8'h76, 8'h30, 8'h0E, 8'h78, 8'h38, 8'h37, 8'h54, 8'h5C,
    8'h73, 8'h67, 8'h50, 8'h2D, 8'h31, 8'h3E, 8'h1C, 8'h6A,
    8'h46, 8'h6E, 8'h1B, 8'h39, 8'h60, 8'h0F, 8'h01, 8'h08
  };

  typedef struct packed {
    logic [1:0]        pad;
    logic              lamp_on;
    logic [1:0]        play_mode;
    logic signed [7:0] min_digits;
    logic [15:0]       number;
    logic [7:0]        pattern;
    logic [7:0]        char_code;
    logic [2:0]        position;
  } cmd_fields_t;

  typedef struct packed {
    logic [2:0] column;
    logic [6:0] seg_n;
  } scan_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // position, char_code, pattern, number, min_digits,
                                   // play_mode, lamp_on, pad
  logic [2:0]  s_axis_tuser = '0;  // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // column_index, segments_low, pad

  // Shadow of the block state
  logic [7:0]  shadow_glyphs [NUM_COLUMNS];
  int unsigned shadow_col;
  scan_beat_t  scan_beats_expected [$];

  int mismatch_count = 0;
  int ticks_sent     = 0;
  int writes_sent    = 0;
  int spare_sent     = 0;
  int beats_checked  = 0;

  // Sender idling
  bit src_idle_on = 1'b1;
  int burst_left  = 4;

  // Receiver stalling
  bit          sink_stall_on = 1'b1;
  bit          hold_req_tgl  = 1'b0;
  bit          hold_seen     = 1'b0;
  int          hold_left     = 0;
  logic [15:0] stall_word    = '0;
  logic [3:0]  stall_phase   = '0;

  int idle_cycles = 0;

  seven_segment_scan_controller #(
    .NUM_DIGITS  (NUM_DIGITS),
    .NUM_COLUMNS (NUM_COLUMNS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] glyph_for(input logic [7:0] code);
    if (code >= FONT_FIRST && code <= FONT_LAST) begin
      return GLYPH_ROM[int'(code - FONT_FIRST)];
    end
    return 8'h00;
  endfunction

  function automatic void store_glyph(input int unsigned pos, input logic [7:0] value);
    if (pos < NUM_COLUMNS) begin
      shadow_glyphs[pos] = value;
    end
  endfunction

  function automatic void apply_display_cmd(input logic [2:0] func, input cmd_fields_t f);
    logic [7:0]  glyph;
    int unsigned rest;
    int          left;
    scan_beat_t  beat;
    case (func)
      FUNC_TICK: begin
        glyph = (shadow_col < NUM_COLUMNS) ? shadow_glyphs[shadow_col] : 8'h00;
        beat.column = shadow_col[2:0];
        beat.seg_n  = ~glyph[6:0];
        scan_beats_expected.push_back(beat);
        shadow_col = (shadow_col + 1) % NUM_COLUMNS;
      end
      FUNC_CHAR: begin
        if (f.position < NUM_DIGITS) begin
          store_glyph(f.position, glyph_for(f.char_code));
        end
      end
      FUNC_PATTERN: store_glyph(f.position, f.pattern);
      FUNC_NUMBER: begin
        rest = f.number;
        left = $signed(f.min_digits);
        // rightmost digit first; blank once value and minimum count run out
        for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
          glyph = (rest > 0 || left > 0) ? GLYPH_ROM[rest % 10] : 8'h00;
          store_glyph(k, glyph);
          left--;
          rest = rest / 10;
        end
      end
      FUNC_MODE: begin
        if (NUM_DIGITS < NUM_COLUMNS) begin
          shadow_glyphs[NUM_DIGITS] = (shadow_glyphs[NUM_DIGITS] & 8'hFC) | {6'd0, f.play_mode};
        end
      end
      FUNC_LAMP: begin
        if (NUM_DIGITS < NUM_COLUMNS) begin
          shadow_glyphs[NUM_DIGITS][4] = f.lamp_on;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic [2:0] func, input cmd_fields_t f);
    int gap;
    f.pad = '0;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= f;
    s_axis_tuser  <= func;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    apply_display_cmd(func, f);
    if (func == FUNC_TICK) ticks_sent++;
    else if (func == FUNC_SPARE_6 || func == FUNC_SPARE_7) spare_sent++;
    else writes_sent++;
    if (src_idle_on) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic send_simple(input logic [2:0] func, input logic [2:0] pos,
                             input logic [7:0] value);
    cmd_fields_t f;
    f = '0;
    f.position  = pos;
    f.char_code = value;
    f.pattern   = value;
    f.play_mode = value[1:0];
    f.lamp_on   = value[0];
    send_cmd(func, f);
  endtask

  task automatic send_number(input logic [15:0] number, input logic signed [7:0] min_digits);
    cmd_fields_t f;
    f = '0;
    f.number     = number;
    f.min_digits = min_digits;
    send_cmd(FUNC_NUMBER, f);
  endtask

  task automatic send_ticks(input int count);
    for (int i = 0; i < count; i++) begin
      send_simple(FUNC_TICK, 3'd0, 8'd0);
    end
  endtask

  // Drop valid and hold until every expected beat has come out
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (scan_beats_expected.size() != 0) @(posedge clk);
  endtask

  function automatic cmd_fields_t random_fields();
    cmd_fields_t f;
    f = cmd_fields_t'({$urandom, $urandom});
    if ($urandom_range(0, 1) == 0) f.char_code = 8'($urandom_range(FONT_FIRST, FONT_LAST));
    case ($urandom_range(0, 9))
      0:       f.number = 16'd0;
      1, 2, 3: f.number = 16'($urandom_range(0, 99));
      4, 5, 6: f.number = 16'($urandom_range(0, 9999));
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0, 1: f.min_digits = 8'($urandom_range(0, 5));
      2:    f.min_digits = -8'sd1 - 8'($urandom_range(0, 2));
      default: ;
    endcase
    return f;
  endfunction

  function automatic logic [2:0] random_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return FUNC_TICK;
    if (r < 55) return FUNC_CHAR;
    if (r < 65) return FUNC_PATTERN;
    if (r < 82) return FUNC_NUMBER;
    if (r < 88) return FUNC_MODE;
    if (r < 94) return FUNC_LAMP;
    if (r < 97) return FUNC_SPARE_6;
    return FUNC_SPARE_7;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall word reloaded each time the phase counter wraps, plus a long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req_tgl != hold_seen) begin
      hold_seen = hold_req_tgl;
      hold_left = SINK_HOLD_CYCLES;
    end
    if (stall_phase == 4'd0) begin
      stall_word = sink_stall_on ? (16'($urandom) & 16'($urandom)) : 16'd0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !stall_word[stall_phase];
    end
    stall_phase = stall_phase + 4'd1;
  end

  // ---------------------------------------------------------------------------
  // Checker and watchdog
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    scan_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (scan_beats_expected.size() == 0) begin
        report_mismatch("unexpected scan beat, column", m_axis_tdata[2:0], -1);
      end else begin
        want = scan_beats_expected.pop_front();
        if (m_axis_tdata[2:0] !== want.column) begin
          report_mismatch("column_index", m_axis_tdata[2:0], want.column);
        end
        if (m_axis_tdata[9:3] !== want.seg_n) begin
          report_mismatch("segments_low", m_axis_tdata[9:3], want.seg_n);
        end
        beats_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no beat moved for %0d cycles", $realtime, idle_cycles);
        $display("FAIL seven_segment_scan_controller");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // font edges, out-of-range codes, ignored positions, indicator bits
    send_simple(FUNC_CHAR, 3'd0, 8'h30);
    send_simple(FUNC_CHAR, 3'd3, 8'h5F);
    send_simple(FUNC_CHAR, 3'd1, 8'h2F);
    send_simple(FUNC_CHAR, 3'd2, 8'h60);
    send_simple(FUNC_CHAR, 3'd4, 8'h41);
    send_simple(FUNC_PATTERN, 3'd4, 8'hFF);
    send_simple(FUNC_PATTERN, 3'd7, 8'h55);
    send_simple(FUNC_MODE, 3'd0, 8'h02);
    send_simple(FUNC_LAMP, 3'd0, 8'h00);
    send_simple(FUNC_SPARE_6, 3'd7, 8'hFF);
    send_ticks(NUM_COLUMNS);
    // widest value with the largest minimum count, then value zero unpadded
    send_number(16'hFFFF, 8'sd127);
    send_simple(FUNC_LAMP, 3'd0, 8'h01);
    send_simple(FUNC_SPARE_7, 3'd0, 8'hFF);
    send_ticks(NUM_COLUMNS);
    send_number(16'h0000, -8'sd128);
    send_simple(FUNC_MODE, 3'd0, 8'h00);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_cmd(random_func(), random_fields());
      // pause every so often until all results are out
      if (i % 250 == 249) wait_drained();
    end
    wait_drained();
  endtask

  task automatic test_output_hold_off();
    src_idle_on = 1'b0;
    hold_req_tgl = !hold_req_tgl;
    for (int i = 0; i < 40; i++) begin
      send_cmd((i % 4 == 3) ? FUNC_NUMBER : FUNC_TICK, random_fields());
    end
    wait_drained();
    src_idle_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    for (int i = 0; i < BACK_TO_BACK; i++) begin
      send_cmd(random_func(), random_fields());
    end
    wait_drained();
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
  endtask

  initial begin
    int drain_wait;
    for (int i = 0; i < NUM_COLUMNS; i++) shadow_glyphs[i] = 8'h00;
    shadow_col = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic();
    test_output_hold_off();
    test_back_to_back();

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    drain_wait = 0;
    while (scan_beats_expected.size() != 0 && drain_wait < WATCHDOG_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (scan_beats_expected.size() != 0) begin
      report_mismatch("scan beats never produced", scan_beats_expected.size(), 0);
    end

    $display("Sent %0d ticks, %0d store writes and %0d undecoded commands;",
             ticks_sent, writes_sent, spare_sent);
    $display("checked %0d scan beats under random idling and a long output hold-off.",
             beats_checked);
    if (mismatch_count == 0) begin
      $display("PASS seven_segment_scan_controller");
    end else begin
      $display("FAIL seven_segment_scan_controller");
    end
    $finish;
  end

endmodule
